// ----- design/rfr_pkg.sv -----
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types, codes and constants for the follower RPC handler.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int LOG_DEPTH    = 32;
  localparam int IDX_BITS     = $clog2(LOG_DEPTH);
  localparam int LEN_BITS     = IDX_BITS + 1;
  localparam int ID_BITS      = 8;
  localparam int PAYLOAD_BITS = 64;
  localparam int APPLY_CAP    = 31;

  localparam logic [1:0] FUNC_VOTE   = 2'd0;
  localparam logic [1:0] FUNC_HEADER = 2'd1;
  localparam logic [1:0] FUNC_ENTRY  = 2'd2;

  localparam logic [1:0] ROLE_FOLLOWER = 2'd0;

  typedef enum logic [1:0] {
    AM_IDLE     = 2'd0,
    AM_MATCHING = 2'd1,
    AM_APPENDING = 2'd2,
    AM_REJECTED = 2'd3
  } amode_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [1:0]              role;
    logic [31:0]             msg_term;
    logic [ID_BITS-1:0]      candidate_id;
    logic [15:0]             log_index;
    logic [31:0]             log_term;
    logic [15:0]             leader_commit;
    logic                    has_entries;
    logic [31:0]             entry_term;
    logic [PAYLOAD_BITS-1:0] entry_payload;
    logic                    last_entry;
  } in_word_t;

  typedef struct packed {
    logic                    kind;
    logic [31:0]             reply_term;
    logic                    success;
    logic                    step_down;
    logic                    restart_timer;
    logic                    overflow;
    logic [4:0]              apply_index;
    logic [31:0]             apply_term;
    logic [PAYLOAD_BITS-1:0] apply_payload;
    logic                    last_result;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word, issue log read
    logic exec;     // evaluate with read data, update state
    logic rd_apply; // issue read of next entry to apply
    logic emit_rep; // drive reply
    logic emit_app; // drive apply word, advance last_applied
  } rfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reply_due;   // exec produced a reply
    logic apply_more;  // entries remain to apply within the cap
  } rfr_sts_t;

endpackage

// ----- design/raft_follower_rpc_handler.sv -----
// ----------------------------------------------------------------------------
// raft_follower_rpc_handler
// Raft follower: vote requests, streamed append-entries, commit and apply.
// ----------------------------------------------------------------------------
// Sequence: the reply strobes in the reply state, after the evaluate state; busy
//   through both for any word that applies nothing, with or without a reply.
// Committed entries then follow: the first in the cycle after the reply, each
//   later one after its own log memory read, then emit; at most 31 per reply.
// Results cannot be held off; out_strobe marks each result word.
// Reset (synchronous, rst_n low): term, vote, commit and apply clear, the log
//   holds only the sentinel. Log contents are not cleared.
module raft_follower_rpc_handler import rfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  rfr_cmd_t cmd;
  rfr_sts_t sts;

  // sequencer: one word in flight at a time
  rfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // state, log memory and result formatting
  rfr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

  // a result never appears while the block is idle
  a_no_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result while idle");

  // a word is never taken on the cycle after one was taken
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("back-to-back accept");

  // the last result of a burst releases the block
  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last_result) |=> !busy) else $error("stuck busy");

endmodule

// ----- design/rfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfr_ctrl
// Sequencer: load, evaluate, reply, then walk committed entries.
// ----------------------------------------------------------------------------
module rfr_ctrl import rfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rfr_sts_t sts,
  output rfr_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_REPLY = 6'b000100,
    S_ARD   = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (sts.reply_due) begin
          cmd.emit_rep = 1'b1;
          if (sts.apply_more) begin
            cmd.rd_apply = 1'b1;
            state_nxt = S_APPLY;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ARD: begin
        cmd.rd_apply = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.emit_app = 1'b1;
        state_nxt = sts.apply_more ? S_ARD : S_IDLE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/rfr_dpath.sv -----
// ----------------------------------------------------------------------------
// rfr_dpath
// Raft state, log memory and result formatting.
// ----------------------------------------------------------------------------
module rfr_dpath import rfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  rfr_cmd_t  cmd,
  output rfr_sts_t  sts,
  output logic      out_valid,
  output out_word_t out_word
);

  // log memory: one write, one registered read port
  logic [31:0]             mem_term [LOG_DEPTH];
  logic [PAYLOAD_BITS-1:0] mem_pay  [LOG_DEPTH];
  logic [31:0]             rd_term_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic                    rd_zero_r; // slot 0 sentinel
  logic [IDX_BITS-1:0]     rd_addr;
  logic                    rd_en;
  logic                    wr_en;
  logic [IDX_BITS-1:0]     wr_addr;

  logic [31:0]         term_r;
  logic [ID_BITS-1:0]  voted_r;
  logic                vvalid_r;
  logic [LEN_BITS-1:0] len_r;
  logic [IDX_BITS-1:0] commit_r, applied_r;
  amode_t              mode_r;
  logic [LEN_BITS-1:0] offs_r;
  logic [15:0]         scommit_r;
  logic [2:0]          sflags_r;
  in_word_t            iw_r;
  logic [5:0]          napp_r;   // applies left in this burst
  logic                rdue_r;
  logic                rok_r, rsd_r, rrt_r, rov_r;

  // read address chosen at load or for the next apply
  logic [LEN_BITS-1:0] last_idx;
  assign last_idx = len_r - LEN_BITS'(1);

  always_comb begin
    rd_addr = '0;
    rd_en   = 1'b0;
    if (cmd.load) begin
      rd_en = 1'b1;
      case (in_word.func)
        FUNC_VOTE:   rd_addr = last_idx[IDX_BITS-1:0];
        FUNC_HEADER: rd_addr = in_word.log_index[IDX_BITS-1:0];
        default:     rd_addr = offs_r[IDX_BITS-1:0];
      endcase
    end else if (cmd.rd_apply) begin
      rd_en   = 1'b1;
      rd_addr = applied_r + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_term[wr_addr] <= iw_r.entry_term;
      mem_pay[wr_addr]  <= iw_r.entry_payload;
    end
    if (rd_en) begin
      rd_term_r <= mem_term[rd_addr];
      rd_pay_r  <= mem_pay[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  logic [31:0] rterm;
  assign rterm = rd_zero_r ? 32'd0 : rd_term_r;

  // evaluation
  logic [31:0]         t_term;
  logic                t_sd, gt;
  logic [ID_BITS-1:0]  n_voted;
  logic                n_vvalid;
  logic [LEN_BITS-1:0] n_len;
  logic [IDX_BITS-1:0] n_commit;
  amode_t              n_mode;
  logic [LEN_BITS-1:0] n_offs;
  logic [15:0]         n_scommit;
  logic [2:0]          n_sflags;
  logic                rep, ok, sd, rt, ov, up, hdr_ok, cur;
  logic [15:0]         craise;
  logic                do_raise;
  logic [LEN_BITS-1:0] pos;
  logic                app_now;

  always_comb begin
    gt = iw_r.msg_term > term_r;
    t_term = gt ? iw_r.msg_term : term_r;
    t_sd = gt && (iw_r.role != ROLE_FOLLOWER);
    cur = iw_r.msg_term >= t_term;
    n_voted = gt ? '0 : voted_r;
    n_vvalid = gt ? 1'b0 : vvalid_r;
    n_len = len_r; n_mode = mode_r; n_offs = offs_r;
    n_scommit = scommit_r; n_sflags = sflags_r;
    rep = 1'b0; ok = 1'b0; sd = 1'b0; rt = 1'b0; ov = 1'b0;
    do_raise = 1'b0; craise = '0;
    wr_en = 1'b0; wr_addr = '0;
    pos = offs_r; app_now = 1'b0;
    up = (iw_r.log_term > rterm) ||
         ((iw_r.log_term == rterm) && (iw_r.log_index >= 16'(last_idx)));
    hdr_ok = cur && (iw_r.log_index < 16'(len_r)) && (rterm == iw_r.log_term);
    case (iw_r.func)
      FUNC_VOTE: begin
        n_mode = AM_IDLE;
        rep = 1'b1; sd = t_sd;
        if (cur && up && (!n_vvalid || n_voted == iw_r.candidate_id)) begin
          ok = 1'b1; n_voted = iw_r.candidate_id; n_vvalid = 1'b1;
        end
        rt = ok && (iw_r.role == ROLE_FOLLOWER);
      end
      FUNC_HEADER: begin
        if (!iw_r.has_entries) begin
          n_mode = AM_IDLE;
          rep = 1'b1; ok = hdr_ok; sd = t_sd;
          do_raise = hdr_ok; craise = iw_r.leader_commit;
        end else begin
          n_scommit = iw_r.leader_commit;
          n_sflags = {1'b0, t_sd, hdr_ok};
          n_offs = hdr_ok ? LEN_BITS'(iw_r.log_index) + LEN_BITS'(1) : '0;
          n_mode = hdr_ok ? AM_MATCHING : AM_REJECTED;
        end
      end
      FUNC_ENTRY: begin
        n_voted = voted_r; n_vvalid = vvalid_r; t_term = term_r;
        if (mode_r != AM_IDLE) begin
          if (mode_r == AM_MATCHING) begin
            if (offs_r < len_r && rterm == iw_r.entry_term) begin
              n_offs = offs_r + LEN_BITS'(1);
            end else begin
              n_len = offs_r; n_mode = AM_APPENDING; app_now = 1'b1;
            end
          end
          if (mode_r == AM_APPENDING || app_now) begin
            pos = app_now ? offs_r : len_r;
            if (pos < LEN_BITS'(LOG_DEPTH)) begin
              wr_en = 1'b1; wr_addr = pos[IDX_BITS-1:0];
              n_len = pos + LEN_BITS'(1); n_offs = n_len;
            end else begin
              n_sflags[2] = 1'b1;
            end
          end
          if (iw_r.last_entry) begin
            rep = 1'b1; ok = n_sflags[0]; sd = n_sflags[1]; ov = n_sflags[2];
            do_raise = n_sflags[0]; craise = n_scommit;
            n_mode = AM_IDLE;
          end
        end
      end
      default: begin
        n_voted = voted_r; n_vvalid = vvalid_r; t_term = term_r;
      end
    endcase
    n_commit = commit_r;
    if (do_raise && craise > 16'(commit_r)) begin
      if (craise > 16'(n_len - LEN_BITS'(1)))
        n_commit = (n_len - LEN_BITS'(1)) > LEN_BITS'(commit_r) ?
                   IDX_BITS'(n_len - LEN_BITS'(1)) : commit_r;
      else
        n_commit = craise[IDX_BITS-1:0];
    end
  end

  // another apply follows the one being emitted now
  logic more_after;
  assign more_after = ((applied_r + IDX_BITS'(1)) < commit_r) && (napp_r > 6'd1);

  // while an apply word is out, look past it
  assign sts.reply_due  = rdue_r;
  assign sts.apply_more = cmd.emit_app ? more_after :
                          ((applied_r < commit_r) && (napp_r != '0));

  always_ff @(posedge clk) begin
    if (cmd.load) iw_r <= in_word;
    if (cmd.exec) begin
      rok_r <= ok; rsd_r <= sd; rrt_r <= rt; rov_r <= ov;
    end
    if (!rst_n) begin
      term_r <= '0; voted_r <= '0; vvalid_r <= 1'b0;
      len_r <= LEN_BITS'(1); commit_r <= '0; applied_r <= '0;
      mode_r <= AM_IDLE; offs_r <= '0; scommit_r <= '0; sflags_r <= '0;
      rdue_r <= 1'b0; napp_r <= '0;
    end else begin
      if (cmd.exec) begin
        term_r <= t_term; voted_r <= n_voted; vvalid_r <= n_vvalid;
        len_r <= n_len; commit_r <= n_commit; mode_r <= n_mode;
        offs_r <= n_offs; scommit_r <= n_scommit; sflags_r <= n_sflags;
        rdue_r <= rep; napp_r <= 6'(APPLY_CAP);
      end
      if (cmd.emit_app) begin
        applied_r <= applied_r + IDX_BITS'(1);
        napp_r <= napp_r - 6'd1;
      end
    end
  end

  // result word; last flag looks one step ahead
  always_comb begin
    out_word = '0;
    out_word.reply_term = term_r;
    out_valid = cmd.emit_rep | cmd.emit_app;
    if (cmd.emit_rep) begin
      out_word.success = rok_r; out_word.step_down = rsd_r;
      out_word.restart_timer = rrt_r; out_word.overflow = rov_r;
      out_word.last_result = !sts.apply_more;
    end else if (cmd.emit_app) begin
      out_word.kind = 1'b1;
      out_word.apply_index = 5'(applied_r + IDX_BITS'(1));
      out_word.apply_term = rd_term_r;
      out_word.apply_payload = rd_pay_r;
      out_word.last_result = !more_after;
    end
  end

endmodule
